// ----- rtl/mlc_pkg.sv -----
package mlc_pkg;

    localparam int FIX_MAX = 48;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    localparam int OC_LEFT   = 0;
    localparam int OC_RIGHT  = 1;
    localparam int OC_TOP    = 2;
    localparam int OC_BOTTOM = 3;

    localparam logic [1:0] CL_SEARCH = 2'd0;
    localparam logic [1:0] CL_ACCEPT = 2'd1;
    localparam logic [1:0] CL_REJECT = 2'd2;

    typedef struct packed {
        logic       valid;
        logic       done;
        logic       vis;
        logic [3:0] code;
    } mlc_ctl_t;

    function automatic logic [3:0] outcode(
        input logic signed [FIX_MAX-1:0] x,
        input logic signed [FIX_MAX-1:0] y,
        input logic signed [FIX_MAX-1:0] wl,
        input logic signed [FIX_MAX-1:0] wr,
        input logic signed [FIX_MAX-1:0] wb,
        input logic signed [FIX_MAX-1:0] wt
    );
        logic [3:0] c;
        c            = 4'd0;
        c[OC_LEFT]   = x < wl;
        c[OC_RIGHT]  = x > wr;
        c[OC_TOP]    = y > wt;
        c[OC_BOTTOM] = y < wb;
        return c;
    endfunction

    function automatic logic [1:0] classify(input logic [3:0] ca, input logic [3:0] cb);
        logic [1:0] k;
        if ((ca | cb) == 4'd0)
        begin
            k = CL_ACCEPT;
        end
        else if ((ca & cb) != 4'd0)
        begin
            k = CL_REJECT;
        end
        else
        begin
            k = CL_SEARCH;
        end
        return k;
    endfunction

endpackage

// ----- rtl/mlc_turn.sv -----
module mlc_turn #(
    parameter int FW   = 24,
    parameter bit SWAP = 1'b1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  mlc_pkg::mlc_ctl_t    ctl_i,
    input  logic signed [FW-1:0] ax_i,
    input  logic signed [FW-1:0] ay_i,
    input  logic signed [FW-1:0] bx_i,
    input  logic signed [FW-1:0] by_i,
    input  logic signed [FW-1:0] rx_i,
    input  logic signed [FW-1:0] ry_i,
    input  logic signed [FW-1:0] wl,
    input  logic signed [FW-1:0] wr,
    input  logic signed [FW-1:0] wb,
    input  logic signed [FW-1:0] wt,
    output mlc_pkg::mlc_ctl_t    ctl_o,
    output logic signed [FW-1:0] ax_o,
    output logic signed [FW-1:0] ay_o,
    output logic signed [FW-1:0] bx_o,
    output logic signed [FW-1:0] by_o,
    output logic signed [FW-1:0] rx_o,
    output logic signed [FW-1:0] ry_o
);

    logic signed [FW-1:0] na_x, na_y, nb_x, nb_y;
    logic [3:0]           ca, cb;
    logic [1:0]           kind;
    mlc_pkg::mlc_ctl_t    ctl_next;
    mlc_pkg::mlc_ctl_t    ctl_reg;
    logic signed [FW-1:0] ax_reg, ay_reg, bx_reg, by_reg;

    always_comb
    begin
        if (SWAP && !ctl_i.done)
        begin
            na_x = bx_i;
            na_y = by_i;
            nb_x = rx_i;
            nb_y = ry_i;
        end
        else
        begin
            na_x = ax_i;
            na_y = ay_i;
            nb_x = bx_i;
            nb_y = by_i;
        end
    end

    assign ca = mlc_pkg::outcode(mlc_pkg::FIX_MAX'(na_x), mlc_pkg::FIX_MAX'(na_y),
                                 mlc_pkg::FIX_MAX'(wl), mlc_pkg::FIX_MAX'(wr),
                                 mlc_pkg::FIX_MAX'(wb), mlc_pkg::FIX_MAX'(wt));
    assign cb = mlc_pkg::outcode(mlc_pkg::FIX_MAX'(nb_x), mlc_pkg::FIX_MAX'(nb_y),
                                 mlc_pkg::FIX_MAX'(wl), mlc_pkg::FIX_MAX'(wr),
                                 mlc_pkg::FIX_MAX'(wb), mlc_pkg::FIX_MAX'(wt));
    assign kind = mlc_pkg::classify(ca, cb);

    always_comb
    begin
        ctl_next = ctl_i;
        if (ctl_i.valid && !ctl_i.done)
        begin
            ctl_next.code = cb;
            if (kind == mlc_pkg::CL_ACCEPT)
            begin
                ctl_next.done = 1'b1;
                ctl_next.vis  = 1'b1;
            end
            else if (kind == mlc_pkg::CL_REJECT)
            begin
                ctl_next.done = 1'b1;
                ctl_next.vis  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg <= na_x;
            ay_reg <= na_y;
            bx_reg <= nb_x;
            by_reg <= nb_y;
        end
    end

    assign ctl_o = ctl_reg;
    assign ax_o  = ax_reg;
    assign ay_o  = ay_reg;
    assign bx_o  = bx_reg;
    assign by_o  = by_reg;
    assign rx_o  = ax_reg;
    assign ry_o  = ay_reg;

endmodule

// ----- rtl/mlc_step.sv -----
module mlc_step #(
    parameter int FW      = 24,
    parameter int EPS_LSB = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  mlc_pkg::mlc_ctl_t    ctl_i,
    input  logic signed [FW-1:0] ax_i,
    input  logic signed [FW-1:0] ay_i,
    input  logic signed [FW-1:0] bx_i,
    input  logic signed [FW-1:0] by_i,
    input  logic signed [FW-1:0] rx_i,
    input  logic signed [FW-1:0] ry_i,
    input  logic signed [FW-1:0] wl,
    input  logic signed [FW-1:0] wr,
    input  logic signed [FW-1:0] wb,
    input  logic signed [FW-1:0] wt,
    output mlc_pkg::mlc_ctl_t    ctl_o,
    output logic signed [FW-1:0] ax_o,
    output logic signed [FW-1:0] ay_o,
    output logic signed [FW-1:0] bx_o,
    output logic signed [FW-1:0] by_o,
    output logic signed [FW-1:0] rx_o,
    output logic signed [FW-1:0] ry_o
);

    localparam logic [FW:0] EPS = (FW+1)'(EPS_LSB);

    logic signed [FW:0]   dx, dy, sx, sy;
    logic [FW:0]          adx, ady;
    logic signed [FW-1:0] mx, my;
    logic                 far, go, hit;
    mlc_pkg::mlc_ctl_t    ctl_reg;
    logic signed [FW-1:0] ax_reg, ay_reg, bx_reg, by_reg, rx_reg, ry_reg;

    assign dx  = (FW+1)'(ax_i) - (FW+1)'(bx_i);
    assign dy  = (FW+1)'(ay_i) - (FW+1)'(by_i);
    assign adx = dx[FW] ? (FW+1)'(-dx) : (FW+1)'(dx);
    assign ady = dy[FW] ? (FW+1)'(-dy) : (FW+1)'(dy);
    assign far = (adx > EPS) || (ady > EPS);
    assign go  = ctl_i.valid && !ctl_i.done && far;

    assign sx = (FW+1)'(ax_i) + (FW+1)'(bx_i);
    assign sy = (FW+1)'(ay_i) + (FW+1)'(by_i);
    assign mx = FW'(sx >>> 1);
    assign my = FW'(sy >>> 1);

    assign hit = |(mlc_pkg::outcode(mlc_pkg::FIX_MAX'(mx), mlc_pkg::FIX_MAX'(my),
                                    mlc_pkg::FIX_MAX'(wl), mlc_pkg::FIX_MAX'(wr),
                                    mlc_pkg::FIX_MAX'(wb), mlc_pkg::FIX_MAX'(wt))
                   & ctl_i.code);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg <= rx_i;
            ry_reg <= ry_i;
            if (go && hit)
            begin
                ax_reg <= ax_i;
                ay_reg <= ay_i;
                bx_reg <= mx;
                by_reg <= my;
            end
            else if (go)
            begin
                ax_reg <= mx;
                ay_reg <= my;
                bx_reg <= bx_i;
                by_reg <= by_i;
            end
            else
            begin
                ax_reg <= ax_i;
                ay_reg <= ay_i;
                bx_reg <= bx_i;
                by_reg <= by_i;
            end
        end
    end

    assign ctl_o = ctl_reg;
    assign ax_o  = ax_reg;
    assign ay_o  = ay_reg;
    assign bx_o  = bx_reg;
    assign by_o  = by_reg;
    assign rx_o  = rx_reg;
    assign ry_o  = ry_reg;

endmodule

// ----- rtl/mlc_round.sv -----
module mlc_round #(
    parameter int CW = 16,
    parameter int FB = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  mlc_pkg::mlc_ctl_t      ctl_i,
    input  logic signed [CW+FB-1:0] ax_i,
    input  logic signed [CW+FB-1:0] ay_i,
    input  logic signed [CW+FB-1:0] bx_i,
    input  logic signed [CW+FB-1:0] by_i,
    input  logic signed [CW+FB-1:0] rx_i,
    input  logic signed [CW+FB-1:0] ry_i,
    input  logic signed [CW+FB-1:0] wl,
    input  logic signed [CW+FB-1:0] wr,
    input  logic signed [CW+FB-1:0] wb,
    input  logic signed [CW+FB-1:0] wt,
    output logic                   out_valid,
    output logic                   visible,
    output logic [CW-1:0]          clip_x_start,
    output logic [CW-1:0]          clip_y_start,
    output logic [CW-1:0]          clip_x_end,
    output logic [CW-1:0]          clip_y_end
);

    localparam int          FW   = CW + FB;
    localparam int          HS   = (FB > 0) ? FB - 1 : 0;
    localparam logic [FW:0] HALF = (FB > 0) ? ((FW+1)'(1) << HS) : '0;

    logic signed [FW-1:0] p [0:3];
    logic [CW-1:0]        q [0:3];
    logic [3:0]           ca, cb;
    logic [1:0]           kind;
    logic                 vis;
    logic                 valid_reg;
    logic                 vis_reg;
    logic [CW-1:0]        q_reg [0:3];

    always_comb
    begin
        if (!ctl_i.done)
        begin
            p[0] = bx_i;
            p[1] = by_i;
            p[2] = rx_i;
            p[3] = ry_i;
        end
        else
        begin
            p[0] = ax_i;
            p[1] = ay_i;
            p[2] = bx_i;
            p[3] = by_i;
        end
    end

    assign ca = mlc_pkg::outcode(mlc_pkg::FIX_MAX'(p[0]), mlc_pkg::FIX_MAX'(p[1]),
                                 mlc_pkg::FIX_MAX'(wl), mlc_pkg::FIX_MAX'(wr),
                                 mlc_pkg::FIX_MAX'(wb), mlc_pkg::FIX_MAX'(wt));
    assign cb = mlc_pkg::outcode(mlc_pkg::FIX_MAX'(p[2]), mlc_pkg::FIX_MAX'(p[3]),
                                 mlc_pkg::FIX_MAX'(wl), mlc_pkg::FIX_MAX'(wr),
                                 mlc_pkg::FIX_MAX'(wb), mlc_pkg::FIX_MAX'(wt));
    assign kind = mlc_pkg::classify(ca, cb);
    assign vis  = ctl_i.done ? ctl_i.vis : (kind != mlc_pkg::CL_REJECT);

    for (genvar i = 0; i < 4; i++)
    begin : g_rnd
        logic          neg;
        logic [FW:0]   mag, r, s;
        assign neg  = p[i][FW-1];
        assign mag  = neg ? (FW+1)'(-((FW+1)'(p[i]))) : (FW+1)'(p[i]);
        assign r    = (mag + HALF) >> FB;
        assign s    = neg ? (FW+1)'(-r) : r;
        assign q[i] = vis ? s[CW-1:0] : '1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= ctl_i.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vis_reg <= vis;
            for (int k = 0; k < 4; k++)
            begin
                q_reg[k] <= q[k];
            end
        end
    end

    assign out_valid    = valid_reg;
    assign visible      = vis_reg;
    assign clip_x_start = q_reg[0];
    assign clip_y_start = q_reg[1];
    assign clip_x_end   = q_reg[2];
    assign clip_y_end   = q_reg[3];

endmodule

// ----- rtl/midpoint_line_clipper.sv -----
// Channel   Dir  Handshake                Payload
// request   in   in_valid / in_ready      x_start, y_start, x_end, y_end
// result    out  out_valid / out_ready    visible, clip_x/y_start, clip_x/y_end
// config    in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// The pipeline holds an entry stage, one stage per halving step for each of
// the two searches, a turn stage, and the rounding and output stage. One request
// enters per cycle while the output is not stalled.
// Reset clears all valid bits and loads the window registers; data is not reset.
// A result held on the output stalls the whole pipeline; nothing is lost.
module midpoint_line_clipper #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8,
    parameter int EPS_LSB    = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  visible,
    output logic [COORD_BITS-1:0] clip_x_start,
    output logic [COORD_BITS-1:0] clip_y_start,
    output logic [COORD_BITS-1:0] clip_x_end,
    output logic [COORD_BITS-1:0] clip_y_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data
);

    localparam int FW = COORD_BITS + FRAC_BITS;
    localparam int NS = FW;

    logic                         adv;
    logic signed [COORD_BITS-1:0] wl_reg, wr_reg, wb_reg, wt_reg;
    logic signed [FW-1:0]         wl, wr, wb, wt;
    logic signed [FW-1:0]         fx0, fy0, fx1, fy1;
    mlc_pkg::mlc_ctl_t            ctl_in;

    mlc_pkg::mlc_ctl_t    c1 [0:NS];
    logic signed [FW-1:0] a1x [0:NS], a1y [0:NS], b1x [0:NS], b1y [0:NS];
    logic signed [FW-1:0] r1x [0:NS], r1y [0:NS];
    mlc_pkg::mlc_ctl_t    c2 [0:NS];
    logic signed [FW-1:0] a2x [0:NS], a2y [0:NS], b2x [0:NS], b2y [0:NS];
    logic signed [FW-1:0] r2x [0:NS], r2y [0:NS];

    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= '0;
            wr_reg <= COORD_BITS'(32767);
            wb_reg <= '0;
            wt_reg <= COORD_BITS'(32767);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mlc_pkg::REG_LEFT:   wl_reg <= cfg_data;
                mlc_pkg::REG_RIGHT:  wr_reg <= cfg_data;
                mlc_pkg::REG_BOTTOM: wb_reg <= cfg_data;
                mlc_pkg::REG_TOP:    wt_reg <= cfg_data;
                default:             wl_reg <= wl_reg;
            endcase
        end
    end

    assign wl  = FW'(wl_reg) <<< FRAC_BITS;
    assign wr  = FW'(wr_reg) <<< FRAC_BITS;
    assign wb  = FW'(wb_reg) <<< FRAC_BITS;
    assign wt  = FW'(wt_reg) <<< FRAC_BITS;
    assign fx0 = FW'($signed(x_start)) <<< FRAC_BITS;
    assign fy0 = FW'($signed(y_start)) <<< FRAC_BITS;
    assign fx1 = FW'($signed(x_end)) <<< FRAC_BITS;
    assign fy1 = FW'($signed(y_end)) <<< FRAC_BITS;

    always_comb
    begin
        ctl_in       = '0;
        ctl_in.valid = in_valid && in_ready;
    end

    mlc_turn #(.FW(FW), .SWAP(1'b0)) u_entry (
        .clk(clk), .rst_n(rst_n), .adv(adv), .ctl_i(ctl_in),
        .ax_i(fx0), .ay_i(fy0), .bx_i(fx1), .by_i(fy1), .rx_i(fx0), .ry_i(fy0),
        .wl(wl), .wr(wr), .wb(wb), .wt(wt),
        .ctl_o(c1[0]), .ax_o(a1x[0]), .ay_o(a1y[0]), .bx_o(b1x[0]), .by_o(b1y[0]),
        .rx_o(r1x[0]), .ry_o(r1y[0])
    );

    for (genvar i = 0; i < NS; i++)
    begin : g_pass1
        mlc_step #(.FW(FW), .EPS_LSB(EPS_LSB)) u_step (
            .clk(clk), .rst_n(rst_n), .adv(adv), .ctl_i(c1[i]),
            .ax_i(a1x[i]), .ay_i(a1y[i]), .bx_i(b1x[i]), .by_i(b1y[i]),
            .rx_i(r1x[i]), .ry_i(r1y[i]),
            .wl(wl), .wr(wr), .wb(wb), .wt(wt),
            .ctl_o(c1[i+1]), .ax_o(a1x[i+1]), .ay_o(a1y[i+1]),
            .bx_o(b1x[i+1]), .by_o(b1y[i+1]), .rx_o(r1x[i+1]), .ry_o(r1y[i+1])
        );
    end

    mlc_turn #(.FW(FW), .SWAP(1'b1)) u_turn (
        .clk(clk), .rst_n(rst_n), .adv(adv), .ctl_i(c1[NS]),
        .ax_i(a1x[NS]), .ay_i(a1y[NS]), .bx_i(b1x[NS]), .by_i(b1y[NS]),
        .rx_i(r1x[NS]), .ry_i(r1y[NS]),
        .wl(wl), .wr(wr), .wb(wb), .wt(wt),
        .ctl_o(c2[0]), .ax_o(a2x[0]), .ay_o(a2y[0]), .bx_o(b2x[0]), .by_o(b2y[0]),
        .rx_o(r2x[0]), .ry_o(r2y[0])
    );

    for (genvar i = 0; i < NS; i++)
    begin : g_pass2
        mlc_step #(.FW(FW), .EPS_LSB(EPS_LSB)) u_step (
            .clk(clk), .rst_n(rst_n), .adv(adv), .ctl_i(c2[i]),
            .ax_i(a2x[i]), .ay_i(a2y[i]), .bx_i(b2x[i]), .by_i(b2y[i]),
            .rx_i(r2x[i]), .ry_i(r2y[i]),
            .wl(wl), .wr(wr), .wb(wb), .wt(wt),
            .ctl_o(c2[i+1]), .ax_o(a2x[i+1]), .ay_o(a2y[i+1]),
            .bx_o(b2x[i+1]), .by_o(b2y[i+1]), .rx_o(r2x[i+1]), .ry_o(r2y[i+1])
        );
    end

    mlc_round #(.CW(COORD_BITS), .FB(FRAC_BITS)) u_round (
        .clk(clk), .rst_n(rst_n), .adv(adv), .ctl_i(c2[NS]),
        .ax_i(a2x[NS]), .ay_i(a2y[NS]), .bx_i(b2x[NS]), .by_i(b2y[NS]),
        .rx_i(r2x[NS]), .ry_i(r2y[NS]),
        .wl(wl), .wr(wr), .wb(wb), .wt(wt),
        .out_valid(out_valid), .visible(visible),
        .clip_x_start(clip_x_start), .clip_y_start(clip_y_start),
        .clip_x_end(clip_x_end), .clip_y_end(clip_y_end)
    );

`ifndef NO_ASSERTIONS
    a_reject_ones: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> clip_x_start == '1 && clip_y_start == '1
                                  && clip_x_end == '1 && clip_y_end == '1)
        else $error("rejected result with coordinates other than -1");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped under stall");

    a_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> c1[0].valid)
        else $error("accepted request missing in entry stage");

    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !c2[NS].valid |=> !out_valid)
        else $error("result appeared without a request behind it");
`endif

endmodule

// ----- sim/midpoint_line_clipper_tb.sv -----
`timescale 1ns / 1ps

module midpoint_line_clipper_tb;

    localparam int CB = 16;
    localparam int FB = 8;
    localparam int EPS = 1;
    localparam int DRAIN = 2 * (CB + FB) + 3 + 10;
    localparam int WATCHDOG = 5000;

    typedef struct packed {
        logic          vis;
        logic [CB-1:0] xs;
        logic [CB-1:0] ys;
        logic [CB-1:0] xe;
        logic [CB-1:0] ye;
    } clip_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [CB-1:0] x_start;
    logic [CB-1:0] y_start;
    logic [CB-1:0] x_end;
    logic [CB-1:0] y_end;
    logic          out_valid;
    logic          out_ready;
    logic          visible;
    logic [CB-1:0] clip_x_start;
    logic [CB-1:0] clip_y_start;
    logic [CB-1:0] clip_x_end;
    logic [CB-1:0] clip_y_end;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [1:0]    cfg_index;
    logic [CB-1:0] cfg_data;

    longint win_left;
    longint win_right;
    longint win_bottom;
    longint win_top;
    clip_t  expected_clips[$];
    int     mismatches;
    int     stall_cycles;
    bit     idling;

    midpoint_line_clipper #(
        .COORD_BITS(CB),
        .FRAC_BITS (FB),
        .EPS_LSB   (EPS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_start     (x_start),
        .y_start     (y_start),
        .x_end       (x_end),
        .y_end       (y_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .visible     (visible),
        .clip_x_start(clip_x_start),
        .clip_y_start(clip_y_start),
        .clip_x_end  (clip_x_end),
        .clip_y_end  (clip_y_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [3:0] region_code(longint x, longint y);
        logic [3:0] c;
        c                     = 4'd0;
        c[mlc_pkg::OC_LEFT]   = x < (win_left <<< FB);
        c[mlc_pkg::OC_RIGHT]  = x > (win_right <<< FB);
        c[mlc_pkg::OC_TOP]    = y > (win_top <<< FB);
        c[mlc_pkg::OC_BOTTOM] = y < (win_bottom <<< FB);
        return c;
    endfunction

    function automatic longint round_coord(longint v);
        longint half;
        half = longint'(1) <<< (FB - 1);
        if (v >= 0)
        begin
            return (v + half) >>> FB;
        end
        return -((-v + half) >>> FB);
    endfunction

    function automatic longint abs_diff(longint a, longint b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic clip_t clip_segment(logic [CB-1:0] xs, logic [CB-1:0] ys,
                                           logic [CB-1:0] xe, logic [CB-1:0] ye);
        longint     ax, ay, bx, by, rx, ry, mx, my;
        logic [3:0] ca, cb;
        int         pass;
        bit         vis;
        clip_t      r;
        ax   = $signed(xs);
        ay   = $signed(ys);
        bx   = $signed(xe);
        by   = $signed(ye);
        ax   = ax <<< FB;
        ay   = ay <<< FB;
        bx   = bx <<< FB;
        by   = by <<< FB;
        pass = 1;
        vis  = 1'b0;
        while (1)
        begin
            ca = region_code(ax, ay);
            cb = region_code(bx, by);
            rx = ax;
            ry = ay;
            if ((ca | cb) == 4'd0)
            begin
                vis = 1'b1;
                break;
            end
            if ((ca & cb) != 4'd0)
            begin
                vis = 1'b0;
                break;
            end
            if (pass > 2)
            begin
                vis = 1'b1;
                break;
            end
            if (cb != 4'd0)
            begin
                while (abs_diff(ax, bx) > EPS || abs_diff(ay, by) > EPS)
                begin
                    mx = (ax + bx) >>> 1;
                    my = (ay + by) >>> 1;
                    if ((region_code(mx, my) & cb) != 4'd0)
                    begin
                        bx = mx;
                        by = my;
                    end
                    else
                    begin
                        ax = mx;
                        ay = my;
                    end
                end
            end
            ax = bx;
            ay = by;
            bx = rx;
            by = ry;
            pass++;
        end
        if (vis)
        begin
            r.vis = 1'b1;
            r.xs  = CB'(round_coord(ax));
            r.ys  = CB'(round_coord(ay));
            r.xe  = CB'(round_coord(bx));
            r.ye  = CB'(round_coord(by));
        end
        else
        begin
            r = '1;
            r.vis = 1'b0;
        end
        return r;
    endfunction

    task automatic send_segment(logic [CB-1:0] xs, logic [CB-1:0] ys,
                                logic [CB-1:0] xe, logic [CB-1:0] ye);
        int gap;
        gap = idling ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        x_start  <= xs;
        y_start  <= ys;
        x_end    <= xe;
        y_end    <= ye;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_clips.push_back(clip_segment(xs, ys, xe, ye));
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_clips.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_window(logic [1:0] idx, logic [CB-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            mlc_pkg::REG_LEFT:   win_left   = $signed(data);
            mlc_pkg::REG_RIGHT:  win_right  = $signed(data);
            mlc_pkg::REG_BOTTOM: win_bottom = $signed(data);
            default:             win_top    = $signed(data);
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_window(int l, int r, int b, int t);
        drain_pipeline();
        write_window(mlc_pkg::REG_LEFT, CB'(l));
        write_window(mlc_pkg::REG_RIGHT, CB'(r));
        write_window(mlc_pkg::REG_BOTTOM, CB'(b));
        write_window(mlc_pkg::REG_TOP, CB'(t));
    endtask

    function automatic logic [CB-1:0] near_range(longint lo, longint hi);
        longint a, b, v;
        a = (lo < hi ? lo : hi) - 300;
        b = (lo < hi ? hi : lo) + 300;
        if (a < -32768)
        begin
            a = -32768;
        end
        if (b > 32767)
        begin
            b = 32767;
        end
        v = a + longint'($urandom_range(0, 32'(b - a)));
        return CB'(v);
    endfunction

    task automatic test_directed();
        idling = 1'b0;
        send_segment(16'd100, 16'd100, 16'd200, 16'd200);
        send_segment(16'hFFF6, 16'd10, 16'hFFF0, 16'd20);
        send_segment(16'hFF00, 16'd500, 16'd500, 16'd500);
        send_segment(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_segment(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_segment(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_segment(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_segment(16'd0, 16'd0, 16'd0, 16'd0);
        set_window(-100, 100, -50, 50);
        send_segment(16'hFE00, 16'd0, 16'd200, 16'd0);
        send_segment(16'd0, 16'hFF00, 16'd0, 16'd100);
        send_segment(16'hFF38, 16'hFF38, 16'd200, 16'd200);
        send_segment(16'd0, 16'd0, 16'd300, 16'd10);
        send_segment(16'd300, 16'd10, 16'd0, 16'd0);
        send_segment(16'hFF9C, 16'd60, 16'hFFA0, 16'd80);
        send_segment(16'hFF00, 16'd100, 16'd0, 16'd300);
        send_segment(16'd100, 16'd50, 16'hFF9C, 16'hFFCE);
        set_window(-32768, 32767, -32768, 32767);
        send_segment(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_segment(16'h1234, 16'hABCD, 16'h5555, 16'hAAAA);
        set_window(100, -100, 50, -50);
        send_segment(16'd0, 16'd0, 16'd10, 16'd10);
        send_segment(16'hFF00, 16'd0, 16'd256, 16'd0);
        send_segment(16'd0, 16'hFF00, 16'd0, 16'd256);
    endtask

    task automatic test_random(int l, int r, int b, int t, int count);
        logic [CB-1:0] c[4];
        set_window(l, r, b, t);
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
            begin
                idling = ($urandom_range(0, 3) != 0);
            end
            for (int k = 0; k < 4; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    c[k] = CB'($urandom);
                end
                else if (k % 2 == 0)
                begin
                    c[k] = near_range(win_left, win_right);
                end
                else
                begin
                    c[k] = near_range(win_bottom, win_top);
                end
            end
            send_segment(c[0], c[1], c[2], c[3]);
        end
    endtask

    always @(posedge clk)
    begin
        clip_t want;
        if (out_valid && out_ready)
        begin
            if (expected_clips.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: vis=%0d %0d %0d %0d %0d", visible,
                             $signed(clip_x_start), $signed(clip_y_start),
                             $signed(clip_x_end), $signed(clip_y_end));
                end
            end
            else
            begin
                want = expected_clips.pop_front();
                if (want.vis !== visible || want.xs !== clip_x_start
                    || want.ys !== clip_y_start || want.xe !== clip_x_end
                    || want.ye !== clip_y_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp vis=%0d %0d %0d %0d %0d got vis=%0d %0d %0d %0d %0d",
                                 want.vis, $signed(want.xs), $signed(want.ys),
                                 $signed(want.xe), $signed(want.ye), visible,
                                 $signed(clip_x_start), $signed(clip_y_start),
                                 $signed(clip_x_end), $signed(clip_y_end));
                    end
                end
            end
        end
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = idling ? $urandom_range(0, 4) : 0;
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG)
        begin
            $display("midpoint_line_clipper_tb failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        x_start      = '0;
        y_start      = '0;
        x_end        = '0;
        y_end        = '0;
        cfg_valid    = 1'b0;
        cfg_index    = mlc_pkg::REG_LEFT;
        cfg_data     = '0;
        mismatches   = 0;
        stall_cycles = 0;
        idling       = 1'b0;
        win_left     = 0;
        win_right    = 32767;
        win_bottom   = 0;
        win_top      = 32767;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(-1000, 1000, -800, 800, 240);
        test_random(0, 32767, 0, 32767, 230);
        test_random(-32768, 32767, -32768, 32767, 230);
        test_random(-20, 30, -5, 40, 240);
        test_random(500, -500, -300, 300, 120);
        test_random(-32768, -32000, 32000, 32767, 120);
        test_random($signed(16'($urandom_range(0, 65535)) & 16'hF000), 2000, -2000,
                    $urandom_range(0, 4000), 240);
        drain_pipeline();

        if (mismatches == 0 && expected_clips.size() == 0)
        begin
            $display("midpoint_line_clipper_tb passed");
        end
        else
        begin
            $display("midpoint_line_clipper_tb failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mlc_pkg.sv
rtl/mlc_turn.sv
rtl/mlc_step.sv
rtl/mlc_round.sv
rtl/midpoint_line_clipper.sv
sim/midpoint_line_clipper_tb.sv
